[rtl/wra_pkg.sv]
// Shared types, constants and tables for the weighted Rayleigh accumulator.
// No dependencies.
`default_nettype none
package wra_pkg;

  localparam int unsigned BINS_DEF         = 288;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic [32:0] EPOCH_PHASE = 33'd1072821600;  // solar epoch less 26 h shift
  localparam logic [32:0] EPOCH_SID   = 33'd1104537600;

  localparam logic [127:0] SID_RATE_W = (128'd10 << 64) / 128'd861642;
  localparam logic [127:0] SID_OFS_W  = (128'd314971 << 64) / 128'd3600000;
  localparam logic [63:0]  SID_RATE   = SID_RATE_W[63:0];
  localparam logic [63:0]  SID_OFFSET = SID_OFS_W[63:0];

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [1:0] REQ_TBL = 2'd0;
  localparam logic [1:0] REQ_EVT = 2'd1;
  localparam logic [1:0] REQ_CLR = 2'd2;

  localparam logic [1:0] CFG_DAY_RATE = 2'd0;
  localparam logic [1:0] CFG_T_START  = 2'd1;
  localparam logic [1:0] CFG_T_END    = 2'd2;
  localparam logic [1:0] CFG_ZEN_LIM  = 2'd3;

  typedef enum logic [2:0] {
    MS_PH_LO = 3'd0,
    MS_PH_HI = 3'd1,
    MS_SD0   = 3'd2,
    MS_SD1   = 3'd3,
    MS_SD2   = 3'd4,
    MS_BIN   = 3'd5,
    MS_WC    = 3'd6,
    MS_WS    = 3'd7
  } mul_sel_e;

  typedef struct packed {
    logic     tbl_we;
    logic     clr;
    logic     set_past;
    logic     ld_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     rd;
    logic     cinit;
    logic     cstep;
    logic [4:0] step;
    logic     q15;
    logic     acc;
    logic     out_ld;
    logic     out_acc;
  } wra_cmd_t;

  typedef struct packed {
    logic ev_ok;
    logic ev_late;
  } wra_sts_t;

  // arctangent of 2^-i in turns * 2^32
  function automatic logic signed [32:0] wra_atan(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage
`default_nettype wire

[rtl/wra_datapath.sv]
// Datapath: config registers, weight table, shared multiplier, CORDIC, accumulators.
// Depends on wra_pkg.
`default_nettype none
module wra_datapath #(
  parameter int unsigned BINS = wra_pkg::BINS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [47:0]       cfg_data_i,
  input  wire logic [8:0]        table_bin_i,
  input  wire logic [23:0]       bin_weight_i,
  input  wire logic [31:0]       event_time_i,
  input  wire logic [23:0]       ra_turns_i,
  input  wire logic [14:0]       zenith_i,
  input  wire wra_pkg::wra_cmd_t cmd_i,
  output wra_pkg::wra_sts_t      sts_o,
  output logic signed [63:0]     sum_cos_o,
  output logic signed [63:0]     sum_sin_o,
  output logic [62:0]            sum_weight_o,
  output logic                   accepted_o,
  output logic                   saturated_o
);
  import wra_pkg::*;

  localparam int unsigned BIN_W = $clog2(BINS);
  localparam logic [10:0] BINS_V = 11'(BINS);

  logic [47:0] day_rate_q;
  logic [31:0] t_start_q, t_end_q;
  logic [14:0] zen_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_rate_q <= 48'd214088524382904;
      t_start_q  <= 32'd0;
      t_end_q    <= 32'hFFFF_FFFF;
      zen_lim_q  <= 15'd8000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DAY_RATE: day_rate_q <= cfg_data_i;
        CFG_T_START:  t_start_q  <= cfg_data_i[31:0];
        CFG_T_END:    t_end_q    <= cfg_data_i[31:0];
        CFG_ZEN_LIM:  zen_lim_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // event filter on the incoming word
  logic past_end_q, sat_q;
  assign sts_o.ev_late = !past_end_q && (event_time_i > t_end_q);
  assign sts_o.ev_ok   = !past_end_q && (event_time_i <= t_end_q) &&
                         (event_time_i >= t_start_q) && (zenith_i <= zen_lim_q);

  // weight table
  logic [23:0] mem [BINS];
  logic [10:0] tb_ext;
  logic [23:0] w_q;
  logic [BIN_W-1:0] bin_q;
  assign tb_ext = 11'(table_bin_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_we && (tb_ext < BINS_V)) begin
      mem[tb_ext[BIN_W-1:0]] <= bin_weight_i;
    end
    if (cmd_i.rd) begin
      w_q <= mem[bin_q];
    end
  end

  logic [31:0] t_q;
  logic [23:0] ra_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      t_q  <= event_time_i;
      ra_q <= ra_turns_i;
    end
  end

  // shared 33x25 signed multiplier, result registered
  logic signed [32:0] ma;
  logic [23:0]        mb;
  logic signed [57:0] prod_q;
  logic               pvalid_q;
  mul_sel_e           psel_q;
  logic signed [16:0] c_q, s_q;
  logic [63:0]        phase_q, sid_q;

  always_comb begin
    ma = $signed({1'b0, t_q}) - $signed(EPOCH_PHASE);
    mb = day_rate_q[23:0];
    case (cmd_i.mul_sel)
      MS_PH_LO: mb = day_rate_q[23:0];
      MS_PH_HI: mb = day_rate_q[47:24];
      MS_SD0: begin
        ma = $signed({1'b0, t_q}) - $signed(EPOCH_SID);
        mb = SID_RATE[23:0];
      end
      MS_SD1: begin
        ma = $signed({1'b0, t_q}) - $signed(EPOCH_SID);
        mb = SID_RATE[47:24];
      end
      MS_SD2: begin
        ma = $signed({1'b0, t_q}) - $signed(EPOCH_SID);
        mb = {8'd0, SID_RATE[63:48]};
      end
      MS_BIN: begin
        ma = $signed({1'b0, phase_q[63:32]});
        mb = 24'(BINS);
      end
      MS_WC: begin
        ma = 33'(c_q);
        mb = w_q;
      end
      MS_WS: begin
        ma = 33'(s_q);
        mb = w_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * $signed({1'b0, mb});
      psel_q <= cmd_i.mul_sel;
    end
  end

  logic [63:0] pext;
  logic signed [63:0] tc_q, ts_q;
  assign pext = 64'(prod_q);

  always_ff @(posedge clk_i) begin
    if (pvalid_q) begin
      case (psel_q)
        MS_PH_LO: phase_q <= pext;
        MS_PH_HI: phase_q <= phase_q + (pext << 24);
        MS_SD0:   sid_q   <= pext + SID_OFFSET;
        MS_SD1:   sid_q   <= sid_q + (pext << 24);
        MS_SD2:   sid_q   <= sid_q + (pext << 48);
        MS_BIN: begin
          if (prod_q[42:32] >= BINS_V) bin_q <= BIN_W'(BINS - 1);
          else bin_q <= prod_q[32 +: BIN_W];
        end
        MS_WC:    tc_q <= $signed(pext);
        MS_WS:    ts_q <= $signed(pext);
        default: ;
      endcase
    end
  end

  // CORDIC rotation
  logic [63:0] angle;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic [1:0] quad_q;
  assign angle = phase_q + {ra_q, 40'd0} - sid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cinit) begin
      x_q    <= CORDIC_X0;
      y_q    <= 34'sd0;
      z_q    <= $signed({3'd0, angle[61:32]});
      quad_q <= angle[63:62];
    end else if (cmd_i.cstep) begin
      if (!z_q[32]) begin
        x_q <= x_q - (y_q >>> cmd_i.step);
        y_q <= y_q + (x_q >>> cmd_i.step);
        z_q <= z_q - wra_atan(cmd_i.step);
      end else begin
        x_q <= x_q + (y_q >>> cmd_i.step);
        y_q <= y_q - (x_q >>> cmd_i.step);
        z_q <= z_q + wra_atan(cmd_i.step);
      end
    end
  end

  function automatic logic signed [16:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] r;
    r = (35'(v) + 35'sd16384) >>> 15;
    if (r > 35'sd32768) return 17'sd32768;
    if (r < -35'sd32768) return -17'sd32768;
    return r[16:0];
  endfunction

  logic signed [16:0] xq, yq;
  assign xq = to_q15(x_q);
  assign yq = to_q15(y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.q15) begin
      case (quad_q)
        2'd0: begin c_q <= xq;  s_q <= yq;  end
        2'd1: begin c_q <= -yq; s_q <= xq;  end
        2'd2: begin c_q <= -xq; s_q <= -yq; end
        default: begin c_q <= yq; s_q <= -xq; end
      endcase
    end
  end

  // saturating accumulators
  logic signed [63:0] cos_tot_q, sin_tot_q;
  logic [62:0]        wt_tot_q;
  logic signed [64:0] cs, ss;
  logic [63:0]        ws;
  logic               c_hi, c_lo, s_hi, s_lo;
  assign cs   = 65'(cos_tot_q) + 65'(tc_q);
  assign ss   = 65'(sin_tot_q) + 65'(ts_q);
  assign ws   = {1'b0, wt_tot_q} + 64'(w_q);
  assign c_hi = cs > 65'sh0_7FFF_FFFF_FFFF_FFFF;
  assign c_lo = cs < -65'sh0_8000_0000_0000_0000;
  assign s_hi = ss > 65'sh0_7FFF_FFFF_FFFF_FFFF;
  assign s_lo = ss < -65'sh0_8000_0000_0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_tot_q  <= '0;
      sin_tot_q  <= '0;
      wt_tot_q   <= '0;
      past_end_q <= 1'b0;
      sat_q      <= 1'b0;
    end else if (cmd_i.clr) begin
      cos_tot_q  <= '0;
      sin_tot_q  <= '0;
      wt_tot_q   <= '0;
      past_end_q <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      if (cmd_i.set_past) past_end_q <= 1'b1;
      if (cmd_i.acc) begin
        cos_tot_q <= c_hi ? 64'sh7FFF_FFFF_FFFF_FFFF :
                     c_lo ? 64'sh8000_0000_0000_0000 : cs[63:0];
        sin_tot_q <= s_hi ? 64'sh7FFF_FFFF_FFFF_FFFF :
                     s_lo ? 64'sh8000_0000_0000_0000 : ss[63:0];
        wt_tot_q  <= ws[63] ? '1 : ws[62:0];
        if (c_hi || c_lo || s_hi || s_lo || ws[63]) sat_q <= 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      sum_cos_o    <= cos_tot_q;
      sum_sin_o    <= sin_tot_q;
      sum_weight_o <= wt_tot_q;
      accepted_o   <= cmd_i.out_acc;
      saturated_o  <= sat_q;
    end
  end

endmodule
`default_nettype wire

[rtl/wra_ctrl.sv]
// Controller: request decode and step sequencing for the datapath.
// Depends on wra_pkg.
`default_nettype none
module wra_ctrl #(
  parameter int unsigned CORDIC_STEPS = wra_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        req_type_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire wra_pkg::wra_sts_t sts_i,
  output wra_pkg::wra_cmd_t      cmd_o
);
  import wra_pkg::*;

  localparam int unsigned SW = $clog2(CORDIC_STEPS);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MUL   = 11'b000_0000_0010,
    S_BINC  = 11'b000_0000_0100,
    S_RD    = 11'b000_0000_1000,
    S_ROT   = 11'b000_0001_0000,
    S_Q15   = 11'b000_0010_0000,
    S_MWC   = 11'b000_0100_0000,
    S_MWS   = 11'b000_1000_0000,
    S_TWAIT = 11'b001_0000_0000,
    S_ACC   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] mcnt_q, mcnt_d;
  logic [SW-1:0] step_q, step_d;
  logic acc_q, acc_d;
  logic ov_q, ov_d;
  logic take;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign take        = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    mcnt_d  = mcnt_q;
    step_d  = step_q;
    acc_d   = acc_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.mul_sel = mul_sel_e'(mcnt_q);
    cmd_o.step    = 5'(step_q);
    cmd_o.out_acc = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          cmd_o.ld_in = 1'b1;
          acc_d   = 1'b0;
          state_d = S_DONE;
          case (req_type_i)
            REQ_TBL: cmd_o.tbl_we = 1'b1;
            REQ_CLR: cmd_o.clr = 1'b1;
            REQ_EVT: begin
              cmd_o.set_past = sts_i.ev_late;
              if (sts_i.ev_ok) begin
                acc_d   = 1'b1;
                mcnt_d  = 3'd0;
                state_d = S_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        mcnt_d = mcnt_q + 3'd1;
        if (mul_sel_e'(mcnt_q) == MS_BIN) state_d = S_BINC;
      end
      S_BINC: state_d = S_RD;
      S_RD: begin
        cmd_o.rd    = 1'b1;
        cmd_o.cinit = 1'b1;
        step_d  = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.cstep = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == SW'(CORDIC_STEPS - 1)) state_d = S_Q15;
      end
      S_Q15: begin
        cmd_o.q15 = 1'b1;
        state_d = S_MWC;
      end
      S_MWC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_WC;
        state_d = S_MWS;
      end
      S_MWS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_WS;
        state_d = S_TWAIT;
      end
      S_TWAIT: state_d = S_ACC;
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.out_ld = 1'b1;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mcnt_q  <= '0;
      step_q  <= '0;
      acc_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mcnt_q  <= mcnt_d;
      step_q  <= step_d;
      acc_q   <= acc_d;
      ov_q    <= ov_d;
    end
  end

endmodule
`default_nettype wire

[rtl/weighted_rayleigh_accumulator.sv]
// Top level of the weighted Rayleigh accumulator: controller plus datapath.
// Depends on wra_pkg, wra_ctrl, wra_datapath.
//
// Usage: one request word in on the in_ channel (valid/stall), one result
// word out on the out_ channel for every request. Request types: table
// write, event, clear. The result carries the running totals after the
// request and whether this word was accumulated.
// Sequence: table write, clear and rejected event go straight to the
// output register. Accepted event: 6 multiply steps, bin, read,
// CORDIC_STEPS rotations, rounding, 2 weight multiplies and the
// accumulate, via the single shared multiplier and iterative CORDIC.
// One request at a time. Stall: a finished result sits in the output
// register; the next request is taken and processed meanwhile, waiting
// only to hand its result over. Reset clears totals, flags and the
// handshake; config registers take their defaults; the weight table is
// undefined until written. Config: cfg_we_i writes cfg_idx_i; the user
// must do so only while the block is idle, which is not enforced.
`default_nettype none
module weighted_rayleigh_accumulator #(
  parameter int unsigned BINS         = wra_pkg::BINS_DEF,
  parameter int unsigned CORDIC_STEPS = wra_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [47:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [8:0]        table_bin_i,
  input  wire logic [23:0]       bin_weight_i,
  input  wire logic [31:0]       event_time_i,
  input  wire logic [23:0]       ra_turns_i,
  input  wire logic [14:0]       zenith_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [63:0]     sum_cos_o,
  output logic signed [63:0]     sum_sin_o,
  output logic [62:0]            sum_weight_o,
  output logic                   accepted_o,
  output logic                   saturated_o
);
  import wra_pkg::*;

  wra_cmd_t cmd;
  wra_sts_t sts;

  wra_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i,
    .out_valid_o, .out_stall_i, .sts_i(sts), .cmd_o(cmd)
  );

  wra_datapath #(.BINS(BINS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .table_bin_i, .bin_weight_i, .event_time_i, .ra_turns_i, .zenith_i,
    .cmd_i(cmd), .sts_o(sts),
    .sum_cos_o, .sum_sin_o, .sum_weight_o, .accepted_o, .saturated_o
  );

  // a taken word always keeps the block busy for the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after taking a word");

  // a new result appears only from the busy hand-over step
  a_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result loaded while idle");

  // accumulate and output load never share a cycle
  a_acc_vs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.acc && cmd.out_ld))
    else $error("accumulate and output load overlap");

endmodule
`default_nettype wire
